// ===== hw/rtl/qmn_pkg.sv =====
// shared constants, payload types and helpers for the quaternion multiply/normalize block
// no dependencies
package qmn_pkg;

    localparam int CW = 16;          // component width, Q2.F
    localparam int F  = CW - 2;      // fraction bits
    localparam int TW = 15;          // threshold register width
    localparam int PW = CW + 4;      // rounded product component, signed
    localparam int QW = CW + 3;      // product magnitude
    localparam int LW = QW + 1;      // length (square root result)
    localparam int SW = 2 * LW;      // sum of squares
    localparam int DW = QW + F;      // division dividend
    localparam int NQ = F + 1;       // quotient bits

    typedef logic signed [CW-1:0] t_comp;
    typedef logic signed [PW-1:0] t_prod;

    typedef struct packed {
        t_comp w;
        t_comp x;
        t_comp y;
        t_comp z;
    } t_quat;

    typedef struct packed {
        t_prod [3:0]  p;
        logic [LW+2:0] rem;
        logic [LW-1:0] root;
        logic [SW-1:0] n;
    } t_sq_pay;

    typedef struct packed {
        logic [LW-1:0] rem;
        logic [NQ-1:0] qb;
    } t_dv_lane;

    typedef struct packed {
        t_dv_lane [3:0] lane;
        t_prod [3:0]    p;
        logic [LW-1:0]  len;
        logic           near;
    } t_dv_pay;

    function automatic logic [QW-1:0] abs_p(input t_prod v);
        logic [PW-1:0] m;
        m = v[PW-1] ? -v : v;
        return m[QW-1:0];
    endfunction

endpackage

// ===== hw/rtl/quaternion_multiply_normalize.sv =====
// Normalized Hamilton product of two Q2.14 quaternions. Takes one request per
// clock while the output side keeps up and returns one result per request, in
// order. The request passes 41 register stages, the first loaded at the
// accepting edge: 4 product stages, a chain of 20 square root cells (one root
// bit each), a setup stage, a chain of 15 divide cells (one quotient bit each,
// all four components side by side) and the output register. Every stage has
// its own valid bit, so bubbles close up and the input keeps taking requests
// while a result waits at the output. When the length is at or below
// zero_threshold the rounded raw product is returned, saturated, with
// o_near_zero set. zero_threshold resets to 1 and is to be written by the user through
// the cfg channel while the block is idle; the block itself does not enforce this.
// depends on qmn_pkg, qmn_front, qmn_sqrt_cell, qmn_div_cell
module quaternion_multiply_normalize (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [qmn_pkg::TW-1:0]   i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [qmn_pkg::CW-1:0] i_a_w,
    input  logic signed [qmn_pkg::CW-1:0] i_a_x,
    input  logic signed [qmn_pkg::CW-1:0] i_a_y,
    input  logic signed [qmn_pkg::CW-1:0] i_a_z,
    input  logic signed [qmn_pkg::CW-1:0] i_b_w,
    input  logic signed [qmn_pkg::CW-1:0] i_b_x,
    input  logic signed [qmn_pkg::CW-1:0] i_b_y,
    input  logic signed [qmn_pkg::CW-1:0] i_b_z,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [qmn_pkg::CW-1:0] o_r_w,
    output logic signed [qmn_pkg::CW-1:0] o_r_x,
    output logic signed [qmn_pkg::CW-1:0] o_r_y,
    output logic signed [qmn_pkg::CW-1:0] o_r_z,
    output logic                     o_near_zero
);
    import qmn_pkg::*;

    logic [TW-1:0] r_thr;

    t_quat qa;
    t_quat qb;

    logic    sq_v [LW+1];
    logic    sq_r [LW+1];
    t_sq_pay sq_p [LW+1];

    logic    dv_v [NQ+1];
    logic    dv_r [NQ+1];
    t_dv_pay dv_p [NQ+1];

    logic    r_pv;
    t_dv_pay r_pp;
    t_dv_pay n_pp;
    logic    prep_rdy;
    logic [DW-1:0] dvd [4];

    logic               r_ov;
    logic               out_rdy;
    t_comp [3:0]        r_res;
    t_comp [3:0]        n_res;
    logic               r_near;
    logic [CW-1:0]      quo [4];
    t_prod              pc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= TW'(1);
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    assign qa = '{w: i_a_w, x: i_a_x, y: i_a_y, z: i_a_z};
    assign qb = '{w: i_b_w, x: i_b_x, y: i_b_y, z: i_b_z};

    qmn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_a     (qa),
        .i_b     (qb),
        .o_valid (sq_v[0]),
        .i_ready (sq_r[0]),
        .o_pay   (sq_p[0])
    );

    for (genvar k = 0; k < LW; k++) begin : g_sqrt
        qmn_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v[k]),
            .o_ready (sq_r[k]),
            .i_pay   (sq_p[k]),
            .o_valid (sq_v[k+1]),
            .i_ready (sq_r[k+1]),
            .o_pay   (sq_p[k+1])
        );
    end

    // setup: threshold test and dividends (q << F) + len/2
    assign prep_rdy = !r_pv || dv_r[0];
    assign sq_r[LW] = prep_rdy;

    always_comb begin
        n_pp      = '0;
        n_pp.p    = sq_p[LW].p;
        n_pp.len  = sq_p[LW].root;
        n_pp.near = sq_p[LW].root <= LW'(r_thr);
        for (int c = 0; c < 4; c++) begin
            dvd[c] = {abs_p(sq_p[LW].p[c]), F'(0)} + DW'(sq_p[LW].root >> 1);
            n_pp.lane[c].rem = LW'(dvd[c][DW-1:NQ]);
            n_pp.lane[c].qb  = dvd[c][NQ-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (prep_rdy) begin
            r_pv <= sq_v[LW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (prep_rdy && sq_v[LW]) r_pp <= n_pp;
    end

    assign dv_v[0] = r_pv;
    assign dv_p[0] = r_pp;

    for (genvar k = 0; k < NQ; k++) begin : g_div
        qmn_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_v[k]),
            .o_ready (dv_r[k]),
            .i_pay   (dv_p[k]),
            .o_valid (dv_v[k+1]),
            .i_ready (dv_r[k+1]),
            .o_pay   (dv_p[k+1])
        );
    end

    // output register: sign, saturation and raw-product bypass
    assign out_rdy     = !r_ov || i_ready;
    assign dv_r[NQ]    = out_rdy;

    always_comb begin
        pc = '0;
        for (int c = 0; c < 4; c++) begin
            pc     = dv_p[NQ].p[c];
            quo[c] = CW'(dv_p[NQ].lane[c].qb);
            if (dv_p[NQ].near) begin
                if (pc > t_prod'((1 << (CW - 1)) - 1)) begin
                    n_res[c] = t_comp'((1 << (CW - 1)) - 1);
                end else if (pc < -t_prod'(1 << (CW - 1))) begin
                    n_res[c] = t_comp'(-(1 << (CW - 1)));
                end else begin
                    n_res[c] = pc[CW-1:0];
                end
            end else begin
                n_res[c] = pc[PW-1] ? -quo[c] : quo[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_rdy) begin
            r_ov <= dv_v[NQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && dv_v[NQ]) begin
            r_res  <= n_res;
            r_near <= dv_p[NQ].near;
        end
    end

    assign o_valid     = r_ov;
    assign o_r_w       = r_res[0];
    assign o_r_x       = r_res[1];
    assign o_r_y       = r_res[2];
    assign o_r_z       = r_res[3];
    assign o_near_zero = r_near;

`ifndef SYNTHESIS
    // a normalized result never exceeds one in magnitude
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_near_zero |->
            o_r_w <= t_comp'(1 << F) && o_r_w >= -t_comp'(1 << F) &&
            o_r_x <= t_comp'(1 << F) && o_r_x >= -t_comp'(1 << F) &&
            o_r_y <= t_comp'(1 << F) && o_r_y >= -t_comp'(1 << F) &&
            o_r_z <= t_comp'(1 << F) && o_r_z >= -t_comp'(1 << F))
        else $error("normalized component out of range");

    // a normalized result is never the zero quaternion
    a_norm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_near_zero |->
            o_r_w != 0 || o_r_x != 0 || o_r_y != 0 || o_r_z != 0)
        else $error("normalized result is zero");

    // the divide chain never sees a zero length when it matters
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv && !r_pp.near |-> r_pp.len != '0)
        else $error("division by zero length");

    // nothing leaves right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule

// ===== hw/rtl/qmn_front.sv =====
// product front end: hamilton product, rounding, squares and sum of squares
// depends on qmn_pkg
module qmn_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  qmn_pkg::t_quat  i_a,
    input  qmn_pkg::t_quat  i_b,
    output logic            o_valid,
    input  logic            i_ready,
    output qmn_pkg::t_sq_pay o_pay
);
    import qmn_pkg::*;

    typedef logic signed [2*CW-1:0] t_mul;
    typedef logic signed [2*CW+1:0] t_acc;

    logic [3:0] r_v;
    logic [3:0] rdy;

    t_mul [3:0][3:0]      r_t;
    t_mul [3:0][3:0]      n_t;
    t_prod [3:0]          r_p2;
    t_prod [3:0]          n_p2;
    t_prod [3:0]          r_p3;
    logic [3:0][2*QW-1:0] r_sq;
    logic [3:0][2*QW-1:0] n_sq;
    t_prod [3:0]          r_p4;
    logic [SW-1:0]        r_n;
    logic [SW-1:0]        n_n;

    t_acc [3:0] sum;
    t_acc [3:0] rnd;

    assign rdy[3] = !r_v[3] || i_ready;
    assign rdy[2] = !r_v[2] || rdy[3];
    assign rdy[1] = !r_v[1] || rdy[2];
    assign rdy[0] = !r_v[0] || rdy[1];
    assign o_ready = rdy[0];
    assign o_valid = r_v[3];

    always_comb begin
        // rows: w, x, y, z; last term of each row is subtracted, in the w row all but the first
        n_t[0][0] = i_a.w * i_b.w;
        n_t[0][1] = i_a.x * i_b.x;
        n_t[0][2] = i_a.y * i_b.y;
        n_t[0][3] = i_a.z * i_b.z;
        n_t[1][0] = i_a.w * i_b.x;
        n_t[1][1] = i_b.w * i_a.x;
        n_t[1][2] = i_a.y * i_b.z;
        n_t[1][3] = i_a.z * i_b.y;
        n_t[2][0] = i_a.w * i_b.y;
        n_t[2][1] = i_b.w * i_a.y;
        n_t[2][2] = i_a.z * i_b.x;
        n_t[2][3] = i_a.x * i_b.z;
        n_t[3][0] = i_a.w * i_b.z;
        n_t[3][1] = i_b.w * i_a.z;
        n_t[3][2] = i_a.x * i_b.y;
        n_t[3][3] = i_a.y * i_b.x;
    end

    always_comb begin
        sum[0] = t_acc'(r_t[0][0]) - t_acc'(r_t[0][1]) - t_acc'(r_t[0][2])
               - t_acc'(r_t[0][3]);
        for (int c = 1; c < 4; c++) begin
            sum[c] = t_acc'(r_t[c][0]) + t_acc'(r_t[c][1]) + t_acc'(r_t[c][2])
                   - t_acc'(r_t[c][3]);
        end
        for (int c = 0; c < 4; c++) begin
            // round half up to F fraction bits
            rnd[c]  = (sum[c] + t_acc'(1 << (F - 1))) >>> F;
            n_p2[c] = rnd[c][PW-1:0];
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_sq[c] = abs_p(r_p2[c]) * abs_p(r_p2[c]);
        end
        n_n = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]) + SW'(r_sq[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) r_v[0] <= i_valid;
            if (rdy[1]) r_v[1] <= r_v[0];
            if (rdy[2]) r_v[2] <= r_v[1];
            if (rdy[3]) r_v[3] <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) r_t <= n_t;
        if (rdy[1] && r_v[0]) r_p2 <= n_p2;
        if (rdy[2] && r_v[1]) begin
            r_p3 <= r_p2;
            r_sq <= n_sq;
        end
        if (rdy[3] && r_v[2]) begin
            r_p4 <= r_p3;
            r_n  <= n_n;
        end
    end

    always_comb begin
        o_pay      = '0;
        o_pay.p    = r_p4;
        o_pay.n    = r_n;
    end

endmodule

// ===== hw/rtl/qmn_sqrt_cell.sv =====
// one step of the digit-by-digit square root, one root bit per cell
// depends on qmn_pkg
module qmn_sqrt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  qmn_pkg::t_sq_pay  i_pay,
    output logic              o_valid,
    input  logic              i_ready,
    output qmn_pkg::t_sq_pay  o_pay
);
    import qmn_pkg::*;

    logic          r_v;
    t_sq_pay       r_pay;
    t_sq_pay       n_pay;
    logic [LW+2:0] rem_sh;
    logic [LW+2:0] trial;
    logic          ge;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_pay   = r_pay;

    always_comb begin
        rem_sh = {i_pay.rem[LW:0], i_pay.n[SW-1 -: 2]};
        trial  = {1'b0, i_pay.root, 2'b01};
        ge     = rem_sh >= trial;
        n_pay      = i_pay;
        n_pay.rem  = ge ? rem_sh - trial : rem_sh;
        n_pay.root = {i_pay.root[LW-2:0], ge};
        n_pay.n    = {i_pay.n[SW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_pay <= n_pay;
    end

endmodule

// ===== hw/rtl/qmn_div_cell.sv =====
// one restoring division step for all four lanes, one quotient bit per cell
// depends on qmn_pkg
module qmn_div_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  qmn_pkg::t_dv_pay  i_pay,
    output logic              o_valid,
    input  logic              i_ready,
    output qmn_pkg::t_dv_pay  o_pay
);
    import qmn_pkg::*;

    logic    r_v;
    t_dv_pay r_pay;
    t_dv_pay n_pay;
    logic [3:0][LW:0] r_sh;
    logic [3:0][LW:0] diff;
    logic [3:0]       ge;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_pay   = r_pay;

    always_comb begin
        n_pay = i_pay;
        for (int c = 0; c < 4; c++) begin
            r_sh[c] = {i_pay.lane[c].rem, i_pay.lane[c].qb[NQ-1]};
            diff[c] = r_sh[c] - {1'b0, i_pay.len};
            ge[c]   = r_sh[c] >= {1'b0, i_pay.len};
            n_pay.lane[c].rem = ge[c] ? diff[c][LW-1:0] : r_sh[c][LW-1:0];
            n_pay.lane[c].qb  = {i_pay.lane[c].qb[NQ-2:0], ge[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_pay <= n_pay;
    end

endmodule

// ===== tb/quaternion_multiply_normalize_tb.sv =====
// testbench for quaternion_multiply_normalize: normalized hamilton product checked
// against an in-bench predictor; depends on qmn_pkg and the block's rtl
module quaternion_multiply_normalize_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qmn_pkg::*;

    typedef struct packed {
        t_quat a;
        t_quat b;
    } t_req;

    typedef struct packed {
        t_quat r;
        logic  near;
    } t_res;

    localparam int LATENCY = 41;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int N_RANDOM = 1620;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [TW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_req in_req = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_comp o_w, o_x, o_y, o_z;
    logic o_near;

    quaternion_multiply_normalize dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_a_w(in_req.a.w), .i_a_x(in_req.a.x), .i_a_y(in_req.a.y), .i_a_z(in_req.a.z),
        .i_b_w(in_req.b.w), .i_b_x(in_req.b.x), .i_b_y(in_req.b.y), .i_b_z(in_req.b.z),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_r_w(o_w), .o_r_x(o_x), .o_r_y(o_y), .o_r_z(o_z), .o_near_zero(o_near)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [TW-1:0] threshold = 1;
    t_req pending_reqs[$];
    t_res expected_results[$];
    int errors = 0;
    bit quiet_phase = 0;
    int hold_off_cycles = 0;
    int idle_cycles = 0;

    // exact four-term sum rounded half up to F fraction bits
    function automatic longint round_product(longint t0, longint t1, longint t2, longint t3);
        longint s;
        s = t0 + t1 + t2 + t3 + (longint'(1) <<< (F - 1));
        return s >>> F;
    endfunction

    function automatic t_comp saturate(longint v);
        if (v > 32767) begin
            return 16'sh7fff;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return t_comp'(v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_res predict_product(t_req q);
        longint aw, ax, ay, az, bw, bx, by, bz;
        longint p[4];
        longint unsigned m[4];
        longint unsigned mx, sum, len, quo;
        int k;
        t_res res;
        aw = q.a.w; ax = q.a.x; ay = q.a.y; az = q.a.z;
        bw = q.b.w; bx = q.b.x; by = q.b.y; bz = q.b.z;
        p[0] = round_product(aw*bw, -(ax*bx), -(ay*by), -(az*bz));
        p[1] = round_product(aw*bx, bw*ax, ay*bz, -(az*by));
        p[2] = round_product(aw*by, bw*ay, az*bx, -(ax*bz));
        p[3] = round_product(aw*bz, bw*az, ax*by, -(ay*bx));
        mx = 0;
        for (int c = 0; c < 4; c++) begin
            m[c] = p[c] < 0 ? -p[c] : p[c];
            if (m[c] > mx) mx = m[c];
        end
        k = 0;
        while ((mx >> k) >= (64'd1 << 30)) k++;
        sum = 0;
        for (int c = 0; c < 4; c++) begin
            m[c] >>= k;
            sum += m[c] * m[c];
        end
        len = int_sqrt(sum);
        res.near = (k == 0 && len <= threshold) || len == 0;
        for (int c = 0; c < 4; c++) begin
            t_comp v;
            if (res.near) begin
                v = saturate(p[c]);
            end else begin
                quo = ((m[c] << F) + (len >> 1)) / len;
                v = saturate(p[c] < 0 ? -longint'(quo) : longint'(quo));
            end
            case (c)
                0: res.r.w = v;
                1: res.r.x = v;
                2: res.r.y = v;
                default: res.r.z = v;
            endcase
        end
        return res;
    endfunction

    // driver: offers queued requests, with random gaps
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                expected_results.push_back(predict_product(in_req));
            end
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    in_valid <= 1'b1;
                    in_req <= pending_reqs.pop_front();
                    if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                        send_gap <= $urandom_range(1, 10);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    int recv_gap = 0;
    always @(posedge i_clk) begin
        t_res got, exp_res;
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                got.r.w = o_w; got.r.x = o_x; got.r.y = o_y; got.r.z = o_z;
                got.near = o_near;
                if (expected_results.size() == 0) begin
                    $error("unexpected result w=%0d", got.r.w);
                    errors++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got.r.w !== exp_res.r.w) begin
                        $error("r_w expected %0d actual %0d", exp_res.r.w, got.r.w);
                        errors++;
                    end
                    if (got.r.x !== exp_res.r.x) begin
                        $error("r_x expected %0d actual %0d", exp_res.r.x, got.r.x);
                        errors++;
                    end
                    if (got.r.y !== exp_res.r.y) begin
                        $error("r_y expected %0d actual %0d", exp_res.r.y, got.r.y);
                        errors++;
                    end
                    if (got.r.z !== exp_res.r.z) begin
                        $error("r_z expected %0d actual %0d", exp_res.r.z, got.r.z);
                        errors++;
                    end
                    if (got.near !== exp_res.near) begin
                        $error("near_zero expected %0d actual %0d", exp_res.near, got.near);
                        errors++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                    recv_gap <= $urandom_range(1, 10);
                end
            end
        end
    end

    // watchdog on cycles with no accepted request or result, hold-off, send gap or cfg write
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off_cycles > 0
                || send_gap > 0 || cfg_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic t_comp rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return t_comp'($urandom_range(0, 64) - 32);
            3: return t_comp'($urandom_range(0, 32768) - 16384);
            default: return t_comp'($urandom);
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req q;
        q.a = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
        q.b = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
        // occasional zero or tiny operand drives the near-zero path
        if ($urandom_range(0, 15) == 0) q.a = '0;
        if ($urandom_range(0, 15) == 0) q.b = {t_comp'(1), t_comp'(0), t_comp'(0), t_comp'(0)};
        return q;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [TW-1:0] v);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        threshold = v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    localparam t_comp ONE = 16'sh4000;

    initial begin
        logic [TW-1:0] settings[4];
        settings = '{15'd0, 15'd16384 & 15'h7fff, 15'd300, 15'd16384 - 1};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: identity, extremes, zero, tiny products, unit axes
        pending_reqs.push_back('{'{ONE, 0, 0, 0}, '{ONE, 0, 0, 0}});
        pending_reqs.push_back('0);
        pending_reqs.push_back('{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
                                 '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}});
        pending_reqs.push_back('{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
                                 '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}});
        pending_reqs.push_back('{'{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000},
                                 '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff}});
        pending_reqs.push_back('{'{1, 0, 0, 0}, '{1, 0, 0, 0}});
        pending_reqs.push_back('{'{ONE, 0, 0, 0}, '{1, 0, 0, 0}});
        pending_reqs.push_back('{'{ONE, 0, 0, 0}, '{2, 0, 0, 0}});
        pending_reqs.push_back('{'{0, ONE, 0, 0}, '{0, 0, ONE, 0}});
        pending_reqs.push_back('{'{0, 0, ONE, 0}, '{0, 0, 0, ONE}});
        pending_reqs.push_back('{'{0, 0, 0, ONE}, '{0, ONE, 0, 0}});
        pending_reqs.push_back('{'{0, 0, 0, -ONE}, '{0, -1, 3, 0}});
        pending_reqs.push_back('{'{16'sh2d41, 0, 16'sh2d41, 0}, '{0, 16'sh2d41, 0, 16'sh2d41}});
        pending_reqs.push_back('{'{16'shffff, 16'shffff, 16'shffff, 16'shffff},
                                 '{16'shffff, 16'shffff, 16'shffff, 16'shffff}});
        pending_reqs.push_back('{'{16'h5555, 16'haaaa, 16'h5555, 16'haaaa},
                                 '{16'haaaa, 16'h5555, 16'haaaa, 16'h5555}});
        wait_drained();

        // each threshold setting, extremes among them
        for (int s = 0; s < 4; s++) begin
            write_threshold(s == 1 ? 15'h7fff : settings[s]);
            for (int i = 0; i < N_RANDOM / 5; i++) pending_reqs.push_back(rand_req());
            if (s == 1) begin
                // long receiver hold-off while the sender keeps offering
                hold_off_cycles = 200;
            end
            wait_drained();
        end

        // back to reset value, no idling at the end
        write_threshold(15'd1);
        quiet_phase = 1;
        for (int i = 0; i < N_RANDOM / 5; i++) pending_reqs.push_back(rand_req());
        wait_drained();

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
